/* hdl/yuv420_crop_rotate_addr_assert.svh */
// Assertion macros for the crop/rotate address block.
`ifndef YUV420_CROP_ROTATE_ADDR_ASSERT_SVH
`define YUV420_CROP_ROTATE_ADDR_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define YCR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define YCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define YCR_ASSERT_IMPL(label, ante, cons, msg)

`define YCR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* hdl/ycr_pkg.sv */
package ycr_pkg;

  localparam int PLANE_W    = 2;
  localparam int COORD_W    = 12;
  localparam int PIX_W      = 8;
  localparam int ADDR_W     = 24;
  localparam int MODE_W     = 2;
  localparam int DIM_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // working width for coordinate sums
  localparam int EW = DIM_W + 1;

  localparam logic [MODE_W-1:0] MODE_CROP     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ROT90    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ROT270M  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE     = 2'd3;

  localparam logic [PLANE_W-1:0] IN_Y    = 2'd0;
  localparam logic [PLANE_W-1:0] IN_V    = 2'd1;
  localparam logic [PLANE_W-1:0] IN_U    = 2'd2;
  localparam logic [PLANE_W-1:0] IN_NONE = 2'd3;

  localparam logic [PLANE_W-1:0] OUT_Y = 2'd0;
  localparam logic [PLANE_W-1:0] OUT_U = 2'd1;
  localparam logic [PLANE_W-1:0] OUT_V = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd4;

  localparam logic [DIM_W-1:0] RST_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd480;

endpackage

/* hdl/yuv420_crop_rotate_addr.sv */
// Crop, rotate and place one sample of a planar YUV 4:2:0 frame.
// Input channel (in_valid/in_stall): one sample per item, with its plane
// (0 Y, 1 V, 2 U), row and column inside that plane, and its byte value.
// Result channel (out_valid/out_stall): output plane (0 Y, 1 U, 2 V), the
// linear offset inside that plane and the unchanged byte. A sample outside
// the frame or the crop window, plane 3 or mode 3 gives no result.
// Config channel (cfg_valid/cfg_ready): index 0 mode, 1/2 input width and
// height, 3/4 crop width and height; dimensions saturate at MAX_DIM. Write
// only while the block is empty. cfg_ready is always high.
// Pipeline: input register, address setup register, multiply-add into the
// output register. A taken item passes these registers in that order;
// one item per cycle sustained while out_stall stays low.
// A stalled output holds; the stall travels back stage by stage, so empty
// stages keep filling and in_stall rises only when every stage is full.
// Reset (rst_n low at a clock edge) empties the pipeline and loads mode 0,
// 640x480 input and 640x480 crop.
`include "yuv420_crop_rotate_addr_assert.svh"

module yuv420_crop_rotate_addr
  import ycr_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PLANE_W-1:0]    in_plane,
  input  logic [COORD_W-1:0]    in_row,
  input  logic [COORD_W-1:0]    in_col,
  input  logic [PIX_W-1:0]      in_pixel,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PLANE_W-1:0]    out_plane,
  output logic [ADDR_W-1:0]     out_address,
  output logic [PIX_W-1:0]      out_value
);

  localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

  logic [MODE_W-1:0] mode_r;
  logic [DIM_W-1:0]  in_width_r, in_height_r, out_width_r, out_height_r;
  logic [DIM_W-1:0]  cfg_dim;

  // stage a: input register
  logic               a_valid_r;
  logic [PLANE_W-1:0] a_plane_r;
  logic [COORD_W-1:0] a_row_r, a_col_r;
  logic [PIX_W-1:0]   a_pix_r;

  // stage b: operands of addr = a * b + c
  logic               b_valid_r;
  logic [EW-1:0]      b_a_r, b_b_r, b_c_r;
  logic [PLANE_W-1:0] b_plane_r;
  logic [PIX_W-1:0]   b_pix_r;

  logic               out_valid_r;
  logic [PLANE_W-1:0] out_plane_r;
  logic [ADDR_W-1:0]  out_address_r;
  logic [PIX_W-1:0]   out_value_r;

  logic adv_o, adv_b, adv_a;

  logic               chroma;
  logic [EW-1:0]      w, h, ow, oh, r, c;
  logic               in_frame, hit;
  logic [EW-1:0]      b_a_nxt, b_b_nxt, b_c_nxt;
  logic [PLANE_W-1:0] b_plane_nxt;
  logic [2*EW-1:0]    mac;

  assign adv_o    = !out_valid_r || !out_stall;
  assign adv_b    = !b_valid_r || adv_o;
  assign adv_a    = !a_valid_r || adv_b;
  assign in_stall = !adv_a;
  assign cfg_ready = 1'b1;

  assign cfg_dim = (32'(cfg_data) > MAX_DIM) ? MAX_DIM_V : cfg_data[DIM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_CROP;
      in_width_r   <= RST_WIDTH;
      in_height_r  <= RST_HEIGHT;
      out_width_r  <= RST_WIDTH;
      out_height_r <= RST_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:       mode_r       <= cfg_data[MODE_W-1:0];
        REG_IN_WIDTH:   in_width_r   <= cfg_dim;
        REG_IN_HEIGHT:  in_height_r  <= cfg_dim;
        REG_OUT_WIDTH:  out_width_r  <= cfg_dim;
        REG_OUT_HEIGHT: out_height_r <= cfg_dim;
        default: ;
      endcase
    end
  end

  // setup: window test and operands
  always_comb begin
    chroma = (a_plane_r != IN_Y);
    w  = chroma ? EW'(in_width_r >> 1)   : EW'(in_width_r);
    h  = chroma ? EW'(in_height_r >> 1)  : EW'(in_height_r);
    ow = chroma ? EW'(out_width_r >> 1)  : EW'(out_width_r);
    oh = chroma ? EW'(out_height_r >> 1) : EW'(out_height_r);
    r  = EW'(a_row_r);
    c  = EW'(a_col_r);
    in_frame = (r < h) && (c < w) && (a_plane_r != IN_NONE);
    hit      = 1'b0;
    b_a_nxt  = '0;
    b_b_nxt  = '0;
    b_c_nxt  = '0;
    unique case (mode_r)
      MODE_CROP: begin
        hit     = in_frame && (r + oh >= h) && (c < ow);
        b_a_nxt = r + oh - h;
        b_b_nxt = ow;
        b_c_nxt = c;
      end
      MODE_ROT90: begin
        hit     = in_frame && (r + oh >= h) && (c < ow);
        b_a_nxt = c;
        b_b_nxt = oh;
        b_c_nxt = h - EW'(1) - r;
      end
      MODE_ROT270M: begin
        hit     = in_frame && (r < oh) && (c + ow >= w);
        b_a_nxt = w - EW'(1) - c;
        b_b_nxt = oh;
        b_c_nxt = oh - EW'(1) - r;
      end
      MODE_NONE: hit = 1'b0;
      default:   hit = 1'b0;
    endcase
    unique case (a_plane_r)
      IN_Y:    b_plane_nxt = OUT_Y;
      IN_V:    b_plane_nxt = OUT_V;
      IN_U:    b_plane_nxt = OUT_U;
      default: b_plane_nxt = OUT_Y;
    endcase
  end

  assign mac = b_a_r * b_b_r + (2*EW)'(b_c_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv_a) begin
        a_valid_r <= in_valid;
      end
      if (adv_b) begin
        b_valid_r <= a_valid_r && hit;
      end
      if (adv_o) begin
        out_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_plane_r <= in_plane;
      a_row_r   <= in_row;
      a_col_r   <= in_col;
      a_pix_r   <= in_pixel;
    end
    if (adv_b) begin
      b_a_r     <= b_a_nxt;
      b_b_r     <= b_b_nxt;
      b_c_r     <= b_c_nxt;
      b_plane_r <= b_plane_nxt;
      b_pix_r   <= a_pix_r;
    end
    if (adv_o) begin
      out_plane_r   <= b_plane_r;
      out_address_r <= mac[ADDR_W-1:0];
      out_value_r   <= b_pix_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_plane   = out_plane_r;
  assign out_address = out_address_r;
  assign out_value   = out_value_r;

  `YCR_ASSERT_IMPL(a_stall_needs_item, in_stall, a_valid_r, "in_stall with empty input stage")
  `YCR_ASSERT_IMPL(b_offset_in_row, b_valid_r, b_c_r < b_b_r, "row offset beyond row length")
  `YCR_ASSERT_IMPL(b_mode_live, b_valid_r, mode_r != MODE_NONE, "item placed while mode is none")
  `YCR_ASSERT_NEXT(b_moves_on, b_valid_r && !out_valid_r, out_valid_r, "setup stage did not advance")
  `YCR_ASSERT_IMPL(dim_saturated, 1'b1, 32'(in_width_r) <= MAX_DIM, "width above MAX_DIM")

endmodule

/* test/yuv420_crop_rotate_addr_test.sv */
module yuv420_crop_rotate_addr_test
  import ycr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM_LIMIT = 4096;
  localparam int PHASE_ITEMS = 90;
  localparam int TOTAL_ITEMS = 870;

  typedef struct packed {
    logic [PLANE_W-1:0] plane;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   pixel;
  } sample_t;

  typedef struct packed {
    logic [PLANE_W-1:0] plane;
    logic [ADDR_W-1:0]  address;
    logic [PIX_W-1:0]   value;
  } placed_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [PLANE_W-1:0] in_plane = '0;
  logic [COORD_W-1:0] in_row = '0;
  logic [COORD_W-1:0] in_col = '0;
  logic [PIX_W-1:0]   in_pixel = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PLANE_W-1:0] out_plane;
  logic [ADDR_W-1:0]  out_address;
  logic [PIX_W-1:0]   out_value;

  // shadow of the geometry registers
  logic [MODE_W-1:0] geo_mode = MODE_CROP;
  logic [DIM_W-1:0]  geo_in_w = RST_WIDTH;
  logic [DIM_W-1:0]  geo_in_h = RST_HEIGHT;
  logic [DIM_W-1:0]  geo_out_w = RST_WIDTH;
  logic [DIM_W-1:0]  geo_out_h = RST_HEIGHT;

  sample_t sample_q[$];
  placed_t placed_q[$];
  int      mismatches = 0;
  logic    in_fire = 1'b0;

  int burst_left = 1;
  int gap_left = 0;
  int stall_left = 0;
  int stall_kind = 0;
  int seg_count = 0;

  placed_t            head;
  logic [PLANE_W-1:0] pred_plane;
  logic [ADDR_W-1:0]  pred_addr;

  yuv420_crop_rotate_addr u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_plane    (in_plane),
    .in_row      (in_row),
    .in_col      (in_col),
    .in_pixel    (in_pixel),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_plane   (out_plane),
    .out_address (out_address),
    .out_value   (out_value)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [DIM_W-1:0] sat_dim(input logic [CFG_DATA_W-1:0] d);
    return (d > DIM_LIMIT) ? DIM_W'(DIM_LIMIT) : d[DIM_W-1:0];
  endfunction

  // output plane and offset of one sample under the current geometry
  function automatic bit place_sample(input logic [PLANE_W-1:0] plane,
                                      input logic [COORD_W-1:0] row,
                                      input logic [COORD_W-1:0] col,
                                      output logic [PLANE_W-1:0] oplane,
                                      output logic [ADDR_W-1:0] addr);
    longint w, h, ow, oh, r, c, a, start;
    oplane = OUT_Y;
    addr = '0;
    if (plane == IN_NONE || geo_mode == MODE_NONE) return 1'b0;
    r = row;
    c = col;
    if (plane == IN_Y) begin
      w = geo_in_w;
      h = geo_in_h;
      ow = geo_out_w;
      oh = geo_out_h;
    end else begin
      w = geo_in_w >> 1;
      h = geo_in_h >> 1;
      ow = geo_out_w >> 1;
      oh = geo_out_h >> 1;
      oplane = (plane == IN_V) ? OUT_V : OUT_U;
    end
    if (r >= h || c >= w) return 1'b0;
    if (geo_mode != MODE_ROT270M) begin
      start = h - oh;
      if (r < start || c >= ow) return 1'b0;
      if (geo_mode == MODE_CROP) a = (r - start) * ow + c;
      else a = c * oh + (oh - 1 - (r - start));
    end else begin
      start = w - ow;
      if (r >= oh || c < start) return 1'b0;
      a = (ow - 1 - (c - start)) * oh + (oh - 1 - r);
    end
    addr = a[ADDR_W-1:0];
    return 1'b1;
  endfunction

  function automatic int rand_dim();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return $urandom_range(2, DIM_LIMIT);
    if (k == 1) return $urandom_range(DIM_LIMIT + 1, 8191);
    return $urandom_range(2, 96);
  endfunction

  function automatic int crop_of(input int raw);
    int eff;
    eff = (raw > DIM_LIMIT) ? DIM_LIMIT : raw;
    if ($urandom_range(0, 6) == 0) return $urandom_range(2, (eff * 2 > 8191) ? 8191 : eff * 2);
    return $urandom_range(2, eff);
  endfunction

  task automatic queue_sample(input logic [PLANE_W-1:0] plane, input int row, input int col,
                              input int pixel);
    sample_t s;
    s.plane = plane;
    s.row = row[COORD_W-1:0];
    s.col = col[COORD_W-1:0];
    s.pixel = pixel[PIX_W-1:0];
    sample_q.push_back(s);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(input int m, input int iw, input int ih, input int ow, input int oh);
    write_reg(REG_MODE, m);
    write_reg(REG_IN_WIDTH, iw);
    write_reg(REG_IN_HEIGHT, ih);
    write_reg(REG_OUT_WIDTH, ow);
    write_reg(REG_OUT_HEIGHT, oh);
  endtask

  // all items taken, all results in, then room for items that place nothing
  task automatic settle();
    @(posedge clk);
    while (sample_q.size() != 0 || in_valid || placed_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic add_random_sample(output bit hit);
    logic [PLANE_W-1:0] plane, op;
    logic [ADDR_W-1:0]  ad;
    int k, p, w, h, ow, oh, rlo, rhi, clo, chi, row, col;
    p = $urandom_range(0, 19);
    if (p == 0) plane = IN_NONE;
    else if (p <= 10) plane = IN_Y;
    else if (p <= 15) plane = IN_V;
    else plane = IN_U;
    if (plane == IN_Y || plane == IN_NONE) begin
      w = geo_in_w;
      h = geo_in_h;
      ow = geo_out_w;
      oh = geo_out_h;
    end else begin
      w = geo_in_w >> 1;
      h = geo_in_h >> 1;
      ow = geo_out_w >> 1;
      oh = geo_out_h >> 1;
    end
    k = $urandom_range(0, 9);
    if (k == 0) begin
      row = $urandom_range(0, 4095);
      col = $urandom_range(0, 4095);
    end else if (k <= 2) begin
      row = $urandom_range(0, h - 1);
      col = $urandom_range(0, w - 1);
    end else begin
      if (geo_mode == MODE_ROT270M) begin
        rlo = 0;
        rhi = ((h < oh) ? h : oh) - 1;
        clo = (w > ow) ? w - ow : 0;
        chi = w - 1;
      end else begin
        rlo = (h > oh) ? h - oh : 0;
        rhi = h - 1;
        clo = 0;
        chi = ((w < ow) ? w : ow) - 1;
      end
      row = $urandom_range(rlo, rhi);
      col = $urandom_range(clo, chi);
    end
    queue_sample(plane, row, col, $urandom_range(0, 255));
    hit = place_sample(plane, row[COORD_W-1:0], col[COORD_W-1:0], op, ad);
  endtask

  // sender: bursts with gaps, payload held while stalled
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        in_plane <= sample_q[0].plane;
        in_row <= sample_q[0].row;
        in_col <= sample_q[0].col;
        in_pixel <= sample_q[0].pixel;
        void'(sample_q.pop_front());
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: segments of no stall, light stall, heavy stall, and every
  // eighth segment a long hold-off
  always @(negedge clk) begin
    if (stall_left == 0) begin
      seg_count = seg_count + 1;
      if (seg_count % 8 == 0) begin
        stall_kind = 3;
        stall_left = $urandom_range(40, 80);
      end else begin
        stall_kind = $urandom_range(0, 2);
        stall_left = $urandom_range(5, 40);
      end
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_kind)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:       geo_mode <= cfg_data[MODE_W-1:0];
          REG_IN_WIDTH:   geo_in_w <= sat_dim(cfg_data);
          REG_IN_HEIGHT:  geo_in_h <= sat_dim(cfg_data);
          REG_OUT_WIDTH:  geo_out_w <= sat_dim(cfg_data);
          REG_OUT_HEIGHT: geo_out_h <= sat_dim(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (place_sample(in_plane, in_row, in_col, pred_plane, pred_addr)) begin
          head.plane = pred_plane;
          head.address = pred_addr;
          head.value = in_pixel;
          placed_q.push_back(head);
        end
      end
      if (out_valid && !out_stall) begin
        if (placed_q.size() == 0) begin
          $display("%0t: unexpected item plane %0d address %0d value %0d", $time,
                   out_plane, out_address, out_value);
          mismatches = mismatches + 1;
        end else begin
          head = placed_q.pop_front();
          if (out_plane !== head.plane) begin
            $display("%0t: out_plane expected %0d actual %0d", $time, head.plane, out_plane);
            mismatches = mismatches + 1;
          end
          if (out_address !== head.address) begin
            $display("%0t: out_address expected %0d actual %0d", $time, head.address,
                     out_address);
            mismatches = mismatches + 1;
          end
          if (out_value !== head.value) begin
            $display("%0t: out_value expected %0d actual %0d", $time, head.value, out_value);
            mismatches = mismatches + 1;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int total, m, iw, ih;
    bit hit;
    total = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset geometry: full 640x480, no rotation
    queue_sample(IN_Y, 0, 0, 8'h00);
    queue_sample(IN_Y, 479, 639, 8'hFF);
    queue_sample(IN_Y, 480, 0, 8'h11);
    queue_sample(IN_Y, 0, 640, 8'h22);
    queue_sample(IN_Y, 4095, 4095, 8'h5A);
    queue_sample(IN_NONE, 10, 10, 8'h33);
    queue_sample(IN_V, 239, 319, 8'h81);
    queue_sample(IN_U, 0, 0, 8'h7E);
    queue_sample(IN_V, 240, 0, 8'h44);
    settle();

    set_geometry(MODE_ROT90, 64, 48, 40, 30);
    queue_sample(IN_Y, 18, 0, 8'h01);
    queue_sample(IN_Y, 17, 0, 8'h02);
    queue_sample(IN_Y, 47, 39, 8'h03);
    queue_sample(IN_Y, 47, 40, 8'h04);
    queue_sample(IN_U, 9, 0, 8'h05);
    settle();

    set_geometry(MODE_ROT270M, 64, 48, 40, 30);
    queue_sample(IN_Y, 0, 24, 8'h06);
    queue_sample(IN_Y, 0, 23, 8'h07);
    queue_sample(IN_Y, 30, 63, 8'h08);
    queue_sample(IN_V, 0, 12, 8'h09);
    queue_sample(IN_U, 14, 31, 8'h0A);
    settle();

    write_reg(REG_MODE, MODE_NONE);
    queue_sample(IN_Y, 20, 20, 8'h0B);
    settle();

    // oversized writes saturate; widest address
    set_geometry(MODE_CROP, 8191, 5000, 4097, DIM_LIMIT);
    queue_sample(IN_Y, 4095, 4095, 8'hFF);
    queue_sample(IN_V, 2047, 2047, 8'h0C);
    settle();

    // crop window larger than the frame
    set_geometry(MODE_ROT270M, 30, 20, 50, 40);
    queue_sample(IN_Y, 0, 0, 8'h0D);
    queue_sample(IN_U, 9, 14, 8'h0E);
    settle();

    // odd sizes
    set_geometry(MODE_ROT90, 33, 21, 17, 11);
    queue_sample(IN_Y, 20, 16, 8'h0F);
    queue_sample(IN_V, 9, 7, 8'h10);
    settle();

    while (total < TOTAL_ITEMS) begin
      m = ($urandom_range(0, 9) == 0) ? int'(MODE_NONE) : $urandom_range(0, 2);
      iw = rand_dim();
      ih = rand_dim();
      set_geometry(m, iw, ih, crop_of(iw), crop_of(ih));
      if (m == MODE_NONE) begin
        repeat (20) add_random_sample(hit);
        total = total + 20;
      end else begin
        repeat (PHASE_ITEMS) add_random_sample(hit);
        total = total + PHASE_ITEMS;
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("yuv420_crop_rotate_addr regression: pass");
    end else begin
      $display("yuv420_crop_rotate_addr regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("yuv420_crop_rotate_addr regression: fail");
    $finish;
  end

endmodule
